// File: rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants for the curve turn PID drive
// Register indexes, fixed field widths, drive limit and the control struct
// that runs the serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pcd_pkg;

  localparam int HEADING_BITS_DEF = 16;
  localparam int GAIN_W           = 16;  // signed Q12.4 gains, Q0.16 ratio
  localparam int MUL_BITS         = 16;  // multiplier digits, one per cycle
  localparam int CNT_W            = $clog2(MUL_BITS);
  localparam int INTEG_W          = 32;
  localparam int DRIVE_W          = 16;
  localparam int THRESH_W         = 15;
  localparam int SETTLE_W         = 8;
  localparam int DRIVE_LIMIT      = 20480;
  localparam int REG_IDX_W        = 3;

  localparam logic [REG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RATIO   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RLEAD   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_THRESH  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE  = 3'd7;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic step;    // take one multiplier digit
    logic negate;  // sign digit of a two's complement multiplier
  } pcd_mac_ctl_t;

endpackage

`default_nettype wire

// File: rtl/pcd_mac.sv
// ----------------------------------------------------------------------------
// pcd_mac: serial shift-add multiply-accumulate
// One multiplier bit per step: the selected addend goes into the high half,
// the sum shifts right one place and the low bit drops into the low half.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_mac import pcd_pkg::*; #(
  parameter int AW = 34
) (
  input  wire logic          clk_i,
  input  wire pcd_mac_ctl_t  ctl_i,
  input  wire logic [AW-1:0] addend_i,
  output logic [AW-1:0]      hi_o,
  output logic [MUL_BITS-1:0] lo_o
);

  logic [AW-1:0]       hi_q, hi_d;
  logic [MUL_BITS-1:0] lo_q, lo_d;
  logic [AW:0]         add_x, sum_w;

  always_comb begin
    add_x = {addend_i[AW-1], addend_i};
    if (ctl_i.negate) begin
      add_x = -add_x;
    end
    sum_w = {hi_q[AW-1], hi_q} + add_x;
    hi_d  = hi_q;
    lo_d  = lo_q;
    if (ctl_i.clear) begin
      hi_d = '0;
      lo_d = '0;
    end else if (ctl_i.step) begin
      hi_d = sum_w[AW:1];
      lo_d = {sum_w[0], lo_q[MUL_BITS-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign hi_o = hi_q;
  assign lo_o = lo_q;

endmodule

`default_nettype wire

// File: rtl/pcd_settle.sv
// ----------------------------------------------------------------------------
// pcd_settle: settle tick counter
// Counts consecutive in-tolerance ticks, saturating, and flags settled.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_settle import pcd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                upd_i,
  input  wire logic                in_tol_i,
  input  wire logic [SETTLE_W-1:0] settle_count_i,
  output logic                     settled_o
);

  logic [SETTLE_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (upd_i) begin
      if (!in_tol_i) begin
        cnt_d = '0;
      end else if (cnt_q != '1) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign settled_o = (cnt_q >= settle_count_i);

endmodule

`default_nettype wire

// File: rtl/pid_curve_turn_drive.sv
// ----------------------------------------------------------------------------
// pid_curve_turn_drive: heading PID with clamped outer/inner wheel drives
// Turns each heading word into left/right motor commands and a settled flag.
// ----------------------------------------------------------------------------
// Each accepted word runs through the states in order: the error is captured
// on acceptance, prep updates integral, derivative and settle count, the
// bit-serial multiply-accumulate runs over the 16 gain bits (all three PID
// terms share each step), clamp follows, the same unit runs over the ratio
// bits for the inner wheel, and done loads the output register. No new word
// is taken before the result is loaded, so a stalled result holds the block
// in done and the next heading word waits. The user writes configuration
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module pid_curve_turn_drive import pcd_pkg::*; #(
  parameter int HEADING_BITS = HEADING_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [REG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [((HEADING_BITS > GAIN_W) ? HEADING_BITS : GAIN_W)-1:0] cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [HEADING_BITS-1:0] heading_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [DRIVE_W-1:0]           left_drive_o,
  output logic [DRIVE_W-1:0]           right_drive_o,
  output logic                         settled_o
);

  localparam int HB = HEADING_BITS;
  localparam int OW = (INTEG_W > HB + 2) ? INTEG_W : HB + 2;
  localparam int AW = OW + 2;
  localparam int SW = AW + MUL_BITS;
  localparam int QW = 20;  // in-range sums fit here
  localparam logic signed [SW-1:0] S_MAX = SW'(DRIVE_LIMIT * 16 + 15);
  localparam logic signed [SW-1:0] S_MIN = -S_MAX;
  localparam logic signed [DRIVE_W-1:0] D_MAX = DRIVE_W'(DRIVE_LIMIT);
  localparam logic signed [DRIVE_W-1:0] D_MIN = -D_MAX;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_CLAMP = 6'b001000,
    ST_RATIO = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;

  // configuration
  logic [HB-1:0]       tgt_q;
  logic [GAIN_W-1:0]   gp_q, gi_q, gd_q, ratio_q;
  logic                rlead_q;
  logic [THRESH_W-1:0] thresh_q;
  logic [SETTLE_W-1:0] scount_q;

  // datapath
  logic [HB:0]          e_q, prev_q;
  logic [HB+1:0]        d_q;
  logic [INTEG_W-1:0]   integ_q;
  logic [GAIN_W-1:0]    gp_sr_q, gi_sr_q, gd_sr_q;
  logic [DRIVE_W-1:0]   outer_q;
  logic [DRIVE_W-1:0]   left_q, right_q;
  logic                 settled_q, out_vld_q;

  logic                 in_acc, out_load;
  logic [HB:0]          e_w, e_mag;
  logic [HB+1:0]        d_w;
  logic [INTEG_W:0]     isum_w;
  logic [INTEG_W-1:0]   integ_w;
  logic [AW-1:0]        ext_e, ext_i, ext_d, ext_o, addend;
  logic [AW-1:0]        mac_hi;
  logic [MUL_BITS-1:0]  mac_lo;
  logic signed [SW-1:0] s_w;
  logic signed [QW-1:0] q_w;
  logic [DRIVE_W-1:0]   outer_w, inner_w;
  logic                 settled_w, in_tol;
  pcd_mac_ctl_t         mac_ctl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_DONE) && (!out_vld_q || !out_stall_i);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q    <= '0;
      gp_q     <= GAIN_W'(256);
      gi_q     <= '0;
      gd_q     <= '0;
      ratio_q  <= GAIN_W'(32768);
      rlead_q  <= 1'b1;
      thresh_q <= THRESH_W'(32);
      scount_q <= SETTLE_W'(5);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET: tgt_q    <= cfg_data_i[HB-1:0];
        REG_GAIN_P: gp_q     <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I: gi_q     <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D: gd_q     <= cfg_data_i[GAIN_W-1:0];
        REG_RATIO:  ratio_q  <= cfg_data_i[GAIN_W-1:0];
        REG_RLEAD:  rlead_q  <= cfg_data_i[0];
        REG_THRESH: thresh_q <= cfg_data_i[THRESH_W-1:0];
        REG_SETTLE: scount_q <= cfg_data_i[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // error, integral, derivative
  always_comb begin
    e_w     = {tgt_q[HB-1], tgt_q} - {heading_i[HB-1], heading_i};
    d_w     = {e_q[HB], e_q} - {prev_q[HB], prev_q};
    isum_w  = {integ_q[INTEG_W-1], integ_q} + {{(INTEG_W-HB){e_q[HB]}}, e_q};
    integ_w = isum_w[INTEG_W-1:0];
    if (isum_w[INTEG_W] != isum_w[INTEG_W-1]) begin
      // saturate toward the sign of the true sum
      integ_w = {isum_w[INTEG_W], {(INTEG_W-1){~isum_w[INTEG_W]}}};
    end
    e_mag  = e_q[HB] ? -e_q : e_q;
    in_tol = (e_mag <= (HB+1)'(thresh_q));
  end

  // addend for the current multiplier digit
  always_comb begin
    ext_e = {{(AW-HB-1){e_q[HB]}}, e_q};
    ext_i = {{(AW-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
    ext_d = {{(AW-HB-2){d_q[HB+1]}}, d_q};
    ext_o = {{(AW-DRIVE_W){outer_q[DRIVE_W-1]}}, outer_q};
    if (state_q == ST_RATIO) begin
      addend = gp_sr_q[0] ? ext_o : '0;
    end else begin
      addend = (gp_sr_q[0] ? ext_e : '0) + (gi_sr_q[0] ? ext_i : '0)
             + (gd_sr_q[0] ? ext_d : '0);
    end
    mac_ctl.clear  = (state_q == ST_PREP) || (state_q == ST_CLAMP);
    mac_ctl.step   = (state_q == ST_MUL) || (state_q == ST_RATIO);
    mac_ctl.negate = (state_q == ST_MUL) && (cnt_q == CNT_W'(MUL_BITS - 1));
  end

  pcd_mac #(
    .AW(AW)
  ) u_mac (
    .clk_i    (clk_i),
    .ctl_i    (mac_ctl),
    .addend_i (addend),
    .hi_o     (mac_hi),
    .lo_o     (mac_lo)
  );

  pcd_settle u_settle (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_i          (state_q == ST_PREP),
    .in_tol_i       (in_tol),
    .settle_count_i (scount_q),
    .settled_o      (settled_w)
  );

  // clamp and divide by 16 toward zero; inner wheel rounding toward zero
  always_comb begin
    s_w = {mac_hi, mac_lo};
    q_w = s_w[QW-1:0] + (s_w[SW-1] ? QW'(15) : QW'(0));
    if (s_w > S_MAX) begin
      outer_w = D_MAX;
    end else if (s_w < S_MIN) begin
      outer_w = D_MIN;
    end else begin
      outer_w = q_w[QW-1:4];
    end
    inner_w = mac_hi[DRIVE_W-1:0]
            + {{(DRIVE_W-1){1'b0}}, (mac_hi[AW-1] && (mac_lo != '0))};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_PREP;
      ST_PREP:  state_d = ST_MUL;
      ST_MUL:   if (cnt_q == CNT_W'(MUL_BITS - 1)) state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_RATIO;
      ST_RATIO: if (cnt_q == CNT_W'(MUL_BITS - 1)) state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      prev_q    <= '0;
      integ_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mac_ctl.step) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == ST_PREP) begin
        integ_q <= integ_w;
        prev_q  <= e_q;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q <= e_w;
    end
    if (state_q == ST_PREP) begin
      d_q     <= d_w;
      gp_sr_q <= gp_q;
      gi_sr_q <= gi_q;
      gd_sr_q <= gd_q;
    end else if (state_q == ST_CLAMP) begin
      outer_q <= outer_w;
      gp_sr_q <= ratio_q;
    end else if (mac_ctl.step) begin
      gp_sr_q <= {1'b0, gp_sr_q[GAIN_W-1:1]};
      gi_sr_q <= {1'b0, gi_sr_q[GAIN_W-1:1]};
      gd_sr_q <= {1'b0, gd_sr_q[GAIN_W-1:1]};
    end
    if (out_load) begin
      left_q    <= rlead_q ? inner_w : outer_q;
      right_q   <= rlead_q ? outer_q : inner_w;
      settled_q <= settled_w;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign settled_o     = settled_q;

  // accepted word always starts the update cycle
  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_PREP))
    else $error("accepted word did not start processing");

  // a result loaded into the output register is presented as valid
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("finished result not presented");

  // both drives stay within the clamp
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(left_drive_o) <= D_MAX && $signed(left_drive_o) >= D_MIN
                  && $signed(right_drive_o) <= D_MAX && $signed(right_drive_o) >= D_MIN))
    else $error("drive outside clamp range");

endmodule

`default_nettype wire
